>>> sv/acmv_pkg.sv
package acmv_pkg;

  localparam int unsigned BLOCK_BYTES = 16;
  localparam int unsigned AES_ROUNDS = 10;

  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_FINISH = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [1:0] CFG_KEY_LOW       = 2'd0;
  localparam logic [1:0] CFG_KEY_HIGH      = 2'd1;
  localparam logic [1:0] CFG_EXPECTED_LOW  = 2'd2;
  localparam logic [1:0] CFG_EXPECTED_HIGH = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic        match;
    logic [31:0] byte_total;
    logic        key_present;
  } out_item_t;

  // queue head handed from the front to the back
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

>>> sv/aes128_cbc_mac_verifier_core.sv
// channel  | handshake                 | payload
// ---------+---------------------------+-------------------------------
// request  | push / full               | request.mode, request.data_byte
// result   | empty / pop               | result.match, .byte_total, .key_present
// config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// data byte: handled in the back end; a block-completing byte or a padded
// finish also runs the iterative aes round unit (one round a cycle)
// finish without padding: passes through the report state to the result register
// rst is synchronous and clears queue, chain state and config registers
// a full result register stalls the back end, the request queue absorbs
// up to QUEUE_DEPTH items meanwhile
module aes128_cbc_mac_verifier_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  acmv_pkg::in_item_t  request,
  output logic                empty,
  input  logic                pop,
  output acmv_pkg::out_item_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  import acmv_pkg::*;

  cmd_t  cmd;
  logic  cmd_pop;
  logic  res_valid;

  // config is always accepted
  assign cfg_ready = 1'b1;
  assign empty     = !res_valid;

  // front: queue of classified items
  acmv_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .request (request),
    .cmd     (cmd),
    .cmd_pop (cmd_pop)
  );

  // back: block assembly, cbc chaining, compare
  acmv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res       (result),
    .res_take  (pop && res_valid)
  );

endmodule

>>> sv/acmv_front.sv
module acmv_front #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  acmv_pkg::in_item_t request,
  output acmv_pkg::cmd_t     cmd,
  input  logic               cmd_pop
);
  import acmv_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  in_item_t        mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = cmd_pop && (count != '0);

  assign cmd.valid = (count != '0);
  assign cmd.item  = mem[rd_ptr];

  // unused mode code is dropped here; the back never sees it
  always_ff @(posedge clk) begin
    if (do_push && request.mode != MODE_UNUSED) begin
      mem[wr_ptr] <= request;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push && request.mode != MODE_UNUSED) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(do_push && request.mode != MODE_UNUSED) - CW'(do_pop);
    end
  end

endmodule

>>> sv/acmv_aes.sv
module acmv_aes (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] din,
  input  logic [127:0] key,
  output logic         done,
  output logic [127:0] dout
);
  import acmv_pkg::*;

  logic [127:0] st;
  logic [127:0] rk;
  logic [3:0]   rnd;
  logic         busy;
  logic [127:0] nk;
  logic [127:0] sr;
  logic [127:0] mc;
  logic [7:0]   rc;

  always_comb begin
    unique case (rnd)
      4'd1:    rc = 8'h01;
      4'd2:    rc = 8'h02;
      4'd3:    rc = 8'h04;
      4'd4:    rc = 8'h08;
      4'd5:    rc = 8'h10;
      4'd6:    rc = 8'h20;
      4'd7:    rc = 8'h40;
      4'd8:    rc = 8'h80;
      4'd9:    rc = 8'h1b;
      4'd10:   rc = 8'h36;
      default: rc = 8'h00;
    endcase
  end

  // next round key
  always_comb begin
    logic [31:0] t;
    t = {SBOX[rk[103:96]], SBOX[rk[127:120]], SBOX[rk[119:112]],
         SBOX[rk[111:104]] ^ rc};
    nk[31:0]   = rk[31:0] ^ t;
    nk[63:32]  = rk[63:32] ^ nk[31:0];
    nk[95:64]  = rk[95:64] ^ nk[63:32];
    nk[127:96] = rk[127:96] ^ nk[95:64];
  end

  // sub bytes and shift rows, then mix columns
  always_comb begin
    logic [7:0] a0, a1, a2, a3, x;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        sr[(c*4+j)*8 +: 8] = SBOX[st[(((c+j)%4)*4+j)*8 +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = sr[(c*4)*8 +: 8];
      a1 = sr[(c*4+1)*8 +: 8];
      a2 = sr[(c*4+2)*8 +: 8];
      a3 = sr[(c*4+3)*8 +: 8];
      x  = a0 ^ a1 ^ a2 ^ a3;
      mc[(c*4)*8 +: 8]   = a0 ^ x ^ xtime(a0 ^ a1);
      mc[(c*4+1)*8 +: 8] = a1 ^ x ^ xtime(a1 ^ a2);
      mc[(c*4+2)*8 +: 8] = a2 ^ x ^ xtime(a2 ^ a3);
      mc[(c*4+3)*8 +: 8] = a3 ^ x ^ xtime(a3 ^ a0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        st   <= din ^ key;
        rk   <= key;
        rnd  <= 4'd1;
        busy <= 1'b1;
      end else if (busy) begin
        st  <= ((rnd == 4'(AES_ROUNDS)) ? sr : mc) ^ nk;
        rk  <= nk;
        rnd <= rnd + 4'd1;
        if (rnd == 4'(AES_ROUNDS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign dout = st;

endmodule

>>> sv/acmv_back.sv
module acmv_back (
  input  logic                clk,
  input  logic                rst,
  input  acmv_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  output logic                res_valid,
  output acmv_pkg::out_item_t res,
  input  logic                res_take
);
  import acmv_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_CRYPT, ST_REPORT} state_t;

  state_t       state;
  logic [63:0]  key_low, key_high, expected_low, expected_high;
  logic [127:0] chain;
  logic [127:0] blk;
  logic [127:0] last;
  logic [3:0]   pos;
  logic [31:0]  cnt;
  logic         fin;

  logic [127:0] blk_add;
  logic [127:0] blk_pad;
  logic         aes_start;
  logic [127:0] aes_din;
  logic         aes_done;
  logic [127:0] aes_dout;
  logic         res_load;

  assign cmd_pop  = (state == ST_IDLE) && cmd.valid;
  assign res_load = (state == ST_REPORT) && (!res_valid || res_take);

  always_comb begin
    blk_add = blk;
    blk_add[pos*8 +: 8] = cmd.item.data_byte;
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      blk_pad[i*8 +: 8] = (4'(i) < pos) ? blk[i*8 +: 8] : 8'h00;
    end
  end

  always_comb begin
    aes_start = 1'b0;
    aes_din   = blk_pad ^ chain;
    if (cmd_pop) begin
      if (cmd.item.mode == MODE_ADD && pos == 4'(BLOCK_BYTES - 1)) begin
        aes_start = 1'b1;
        aes_din   = blk_add ^ chain;
      end else if (cmd.item.mode == MODE_FINISH && pos != '0) begin
        aes_start = 1'b1;
      end
    end
  end

  acmv_aes u_aes (
    .clk   (clk),
    .rst   (rst),
    .start (aes_start),
    .din   (aes_din),
    .key   ({key_high, key_low}),
    .done  (aes_done),
    .dout  (aes_dout)
  );

  always_ff @(posedge clk) begin
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_LOW:       key_low       <= cfg_data;
        CFG_KEY_HIGH:      key_high      <= cfg_data;
        CFG_EXPECTED_LOW:  expected_low  <= cfg_data;
        CFG_EXPECTED_HIGH: expected_high <= cfg_data;
        default:           ;
      endcase
    end
    if (rst) begin
      key_low       <= '0;
      key_high      <= '0;
      expected_low  <= '0;
      expected_high <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      chain     <= '0;
      last      <= '0;
      blk       <= '0;
      pos       <= '0;
      cnt       <= '0;
      fin       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_take) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_pop) begin
            unique case (cmd.item.mode)
              MODE_START: begin
                chain <= '0;
                last  <= '0;
                blk   <= '0;
                pos   <= '0;
                cnt   <= '0;
              end
              MODE_ADD: begin
                blk <= blk_add;
                pos <= pos + 4'd1;
                cnt <= cnt + 32'd1;
                if (aes_start) begin
                  fin   <= 1'b0;
                  state <= ST_CRYPT;
                end
              end
              MODE_FINISH: begin
                if (aes_start) begin
                  cnt   <= cnt + 32'(5'(BLOCK_BYTES) - {1'b0, pos});
                  pos   <= '0;
                  fin   <= 1'b1;
                  state <= ST_CRYPT;
                end else begin
                  state <= ST_REPORT;
                end
              end
              default: ;
            endcase
          end
        end
        ST_CRYPT: begin
          if (aes_done) begin
            chain <= aes_dout;
            last  <= aes_dout;
            blk   <= aes_dout;
            state <= fin ? ST_REPORT : ST_IDLE;
          end
        end
        ST_REPORT: begin
          if (res_load) begin
            res.match       <= (last == {expected_high, expected_low});
            res.byte_total  <= cnt;
            res.key_present <= !(&{key_high, key_low});
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_done_in_crypt: assert property (@(posedge clk) disable iff (rst)
    aes_done |-> state == ST_CRYPT) else $error("aes done outside crypt");

  a_no_pop_in_crypt: assert property (@(posedge clk) disable iff (rst)
    state == ST_CRYPT |-> !cmd_pop) else $error("queue popped during crypt");

  a_crypt_pos_zero: assert property (@(posedge clk) disable iff (rst)
    state == ST_CRYPT |-> pos == '0) else $error("block position not cleared");

  a_report_fills: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPORT && !res_valid) |=> res_valid) else $error("result lost");

endmodule

>>> tb/sv/aes128_cbc_mac_verifier_core_tb.sv
module aes128_cbc_mac_verifier_core_tb;
  import acmv_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;  // aes rounds plus back end, with margin

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  in_item_t    request = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_KEY_LOW;
  logic [63:0] cfg_data = '0;

  aes128_cbc_mac_verifier_core dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .request(request),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow of the block: config registers and check state, byte i at [8*i +: 8]
  logic [127:0] aes_key;
  logic [127:0] sig_expected;
  logic [127:0] mac_chain;
  logic [127:0] fill_buf;
  logic [127:0] mac_final;
  logic [3:0]   fill_pos;
  logic [31:0]  absorbed;

  out_item_t pending_results[$];
  int        errors = 0;
  int        cycles = 0;
  bit        no_idle = 1'b0;
  bit        hold_off = 1'b0;

  // directed rows; want_typed marks a result read straight off the spec
  typedef struct {
    in_item_t  item;
    bit        want_typed;
    out_item_t want;
  } vector_t;

  function automatic logic [7:0] gf_double(input logic [7:0] b);
    gf_double = (b << 1) ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] aes_encrypt_block(input logic [127:0] pt,
                                                     input logic [127:0] k);
    logic [7:0] rk [176];
    logic [7:0] st [16];
    logic [7:0] sh [16];
    logic [7:0] a0, a1, a2, a3, tmp, x;
    logic [7:0] rc;
    logic [127:0] ct;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) rk[i] = k[8*i +: 8];
    // key schedule
    for (int i = 16; i < 176; i += 4) begin
      a0 = rk[i-4]; a1 = rk[i-3]; a2 = rk[i-2]; a3 = rk[i-1];
      if (i % 16 == 0) begin
        tmp = a0;
        a0 = SBOX[a1] ^ rc;
        a1 = SBOX[a2]; a2 = SBOX[a3]; a3 = SBOX[tmp];
        rc = gf_double(rc);
      end
      rk[i] = rk[i-16] ^ a0; rk[i+1] = rk[i-15] ^ a1;
      rk[i+2] = rk[i-14] ^ a2; rk[i+3] = rk[i-13] ^ a3;
    end
    for (int i = 0; i < 16; i++) st[i] = pt[8*i +: 8] ^ rk[i];
    for (int r = 1; r <= 10; r++) begin
      // sub bytes and shift rows together
      for (int c = 0; c < 4; c++)
        for (int j = 0; j < 4; j++)
          sh[c*4 + j] = SBOX[st[((c + j) % 4)*4 + j]];
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = sh[c*4]; a1 = sh[c*4+1]; a2 = sh[c*4+2]; a3 = sh[c*4+3];
          x = a0 ^ a1 ^ a2 ^ a3;
          sh[c*4]   = a0 ^ x ^ gf_double(a0 ^ a1);
          sh[c*4+1] = a1 ^ x ^ gf_double(a1 ^ a2);
          sh[c*4+2] = a2 ^ x ^ gf_double(a2 ^ a3);
          sh[c*4+3] = a3 ^ x ^ gf_double(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] = sh[i] ^ rk[r*16 + i];
    end
    for (int i = 0; i < 16; i++) ct[8*i +: 8] = st[i];
    return ct;
  endfunction

  function automatic void clear_mac();
    mac_chain = '0; fill_buf = '0; mac_final = '0;
    fill_pos = '0; absorbed = '0;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    fill_buf[8*fill_pos +: 8] = b;
    fill_pos = fill_pos + 4'd1;
    absorbed = absorbed + 32'd1;
    if (fill_pos == 4'd0) begin
      mac_chain = aes_encrypt_block(fill_buf ^ mac_chain, aes_key);
      mac_final = mac_chain;
    end
  endfunction

  // advance the shadow by one accepted item, queue a result on finish
  function automatic void predict_mac(input in_item_t it);
    out_item_t r;
    case (it.mode)
      MODE_START: clear_mac();
      MODE_ADD:   absorb_byte(it.data_byte);
      MODE_FINISH: begin
        while (fill_pos != 4'd0) absorb_byte(8'h00);
        r.match = (mac_final == sig_expected);
        r.byte_total = absorbed;
        r.key_present = (aes_key != {128{1'b1}});
        pending_results.push_back(r);
      end
      default: ;  // unused mode, ignored
    endcase
  endfunction

  // sender: optional gap, then hold the item until the queue takes it
  task automatic send_item(input in_item_t it);
    int gap;
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    request <= it;
    do @(posedge clk); while (full);
    predict_mac(it);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_KEY_LOW:       aes_key[63:0] = val;
      CFG_KEY_HIGH:      aes_key[127:64] = val;
      CFG_EXPECTED_LOW:  sig_expected[63:0] = val;
      CFG_EXPECTED_HIGH: sig_expected[127:64] = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // block must be idle before a register write; aes work on a completed block may still run
  task automatic wait_idle();
    @(negedge clk);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    int r;
    r = $urandom_range(0, 99);
    it.data_byte = $urandom_range(0, 255);
    if (r < 2)       it.mode = MODE_START;
    else if (r < 4)  it.mode = MODE_UNUSED;  // must be ignored
    else if (r < 10) it.mode = MODE_FINISH;
    else             it.mode = MODE_ADD;
    return it;
  endfunction

  function automatic in_item_t mk(input logic [1:0] m, input logic [7:0] d);
    in_item_t it;
    it.mode = m;
    it.data_byte = d;
    return it;
  endfunction

  // receiver: random pop with short and long stalls, plus the forced hold-off
  initial begin
    int stall;
    int held;
    stall = 0;
    held = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        pop <= 1'b0;
        held++;
        if (held >= HOLD_CYCLES) begin
          hold_off = 1'b0;
          held = 0;
        end
      end else if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else if (!no_idle && $urandom_range(0, 49) == 0) begin
        pop <= 1'b0;
        stall = $urandom_range(20, 60);
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        pop <= 1'b0;
        stall = $urandom_range(0, 2);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // result checker, field by field against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %p", $time, result);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (result.match !== want.match) begin
          $display("%0t: match: expected %0b, actual %0b", $time, want.match, result.match);
          errors++;
        end
        if (result.byte_total !== want.byte_total) begin
          $display("%0t: byte_total: expected %0d, actual %0d", $time,
                   want.byte_total, result.byte_total);
          errors++;
        end
        if (result.key_present !== want.key_present) begin
          $display("%0t: key_present: expected %0b, actual %0b", $time,
                   want.key_present, result.key_present);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("aes128_cbc_mac_verifier_core_tb: errors");
      $finish;
    end
  end

  initial begin
    vector_t   vectors[$];
    vector_t   v;
    out_item_t typed;
    logic [63:0] key_lo, key_hi, exp_lo, exp_hi;
    int n;

    aes_key = '0;
    sig_expected = '0;
    clear_mac();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // finish on an empty check compares all zeros against the zero reset signature
    typed.match = 1'b1; typed.byte_total = 32'd0; typed.key_present = 1'b1;
    v.want_typed = 1'b0;
    v.want = '0;
    v.item = mk(MODE_FINISH, 8'h00); v.want_typed = 1'b1; v.want = typed; vectors.push_back(v);
    v.want_typed = 1'b0;
    v.item = mk(MODE_UNUSED, 8'hff); vectors.push_back(v);
    v.item = mk(MODE_ADD, 8'h00);    vectors.push_back(v);
    v.item = mk(MODE_ADD, 8'hff);    vectors.push_back(v);
    v.item = mk(MODE_ADD, 8'h55);    vectors.push_back(v);
    v.item = mk(MODE_ADD, 8'haa);    vectors.push_back(v);
    // padded finish, then a second finish with nothing new
    v.item = mk(MODE_FINISH, 8'hff); vectors.push_back(v);
    v.item = mk(MODE_FINISH, 8'h00); vectors.push_back(v);
    v.item = mk(MODE_ADD, 8'h80);    vectors.push_back(v);
    v.item = mk(MODE_START, 8'hff);  vectors.push_back(v);
    v.item = mk(MODE_FINISH, 8'h00); v.want_typed = 1'b1; v.want = typed; vectors.push_back(v);
    v.want_typed = 1'b0;
    v.item = mk(MODE_ADD, 8'h01);    vectors.push_back(v);
    v.item = mk(MODE_ADD, 8'h7f);    vectors.push_back(v);
    v.item = mk(MODE_UNUSED, 8'h00); vectors.push_back(v);
    v.item = mk(MODE_FINISH, 8'h00); vectors.push_back(v);

    foreach (vectors[i]) begin
      send_item(vectors[i].item);
      // overwrite the prediction with the spec value where one is given
      if (vectors[i].want_typed) pending_results[$] = vectors[i].want;
    end

    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      case (phase)
        0: begin key_lo = '1; key_hi = '1; exp_lo = '1; exp_hi = '1; end
        1: begin key_lo = '0; key_hi = '0; exp_lo = '0; exp_hi = '0; end
        2: begin key_lo = '1; key_hi = {$urandom, $urandom}; exp_lo = '1; exp_hi = '0; end
        default: begin
          key_lo = {$urandom, $urandom}; key_hi = {$urandom, $urandom};
          exp_lo = {$urandom, $urandom}; exp_hi = {$urandom, $urandom};
        end
      endcase
      write_reg(CFG_KEY_LOW, key_lo);
      write_reg(CFG_KEY_HIGH, key_hi);
      write_reg(CFG_EXPECTED_LOW, exp_lo);
      write_reg(CFG_EXPECTED_HIGH, exp_hi);
      no_idle = (phase == 3);

      send_item(mk(MODE_START, 8'h00));
      n = 0;
      while (n < 110) begin
        send_item(random_item());
        n++;
        // long receiver hold-off with a burst of finishes to fill the block
        if (phase == 2 && n == 50) begin
          hold_off = 1'b1;
          repeat (12) send_item(mk(MODE_FINISH, $urandom_range(0, 255)));
        end
      end

      // load the running mac as the signature so a finish matches
      wait_idle();
      while (fill_pos != 4'd0) send_item(mk(MODE_ADD, $urandom_range(0, 255)));
      wait_idle();
      write_reg(CFG_EXPECTED_LOW, mac_final[63:0]);
      write_reg(CFG_EXPECTED_HIGH, mac_final[127:64]);
      send_item(mk(MODE_FINISH, 8'h00));
    end

    @(negedge clk);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("aes128_cbc_mac_verifier_core_tb: clean");
    end else begin
      $display("aes128_cbc_mac_verifier_core_tb: errors");
    end
    $finish;
  end

endmodule
